// ----- design/nftl_pkg.sv -----
// Shared types and constants of the nearest-frequency tuner table.
// Used by nftl_ctrl, nftl_dp and nearest_frequency_table_lookup; no dependencies.
`default_nettype none

package nftl_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = IDX_W + 1;
	localparam int OUT_IDX_W     = 8;

	// field widths
	localparam int FREQ_W = 24;
	localparam int PORT_W = 4;
	localparam int STEP_W = 16;
	localparam int BAND_W = 16;
	localparam int OP_W   = 2;
	localparam int STS_W  = 2;

	localparam logic [BAND_W-1:0] BAND_RESET = BAND_W'(1000);

	// opcodes
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	// result status codes
	localparam logic [STS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STS_W-1:0] ST_MATCH     = 2'd2;
	localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd3;

	// one stored table entry
	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [PORT_W-1:0] ant;
		logic [PORT_W-1:0] xfer;
		logic [PORT_W-1:0] shape;
		logic [STEP_W-1:0] inductor;
		logic [STEP_W-1:0] capacitor;
	} entry_t;

	// one result item
	typedef struct packed {
		logic [STS_W-1:0]     status;
		logic [OUT_IDX_W-1:0] index;
		entry_t               entry;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic latch_in;
		logic exec;
		logic scan_start;
		logic scan_run;
		logic load_res;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_hit;
		logic scan_end;
	} dp_sts_t;

endpackage

`default_nettype wire

// ----- design/nftl_ctrl.sv -----
// Controller of the tuner table: sequences clear, append and query items.
// Depends on nftl_pkg for the command and status structs and opcodes.
`default_nettype none

module nftl_ctrl (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire  [nftl_pkg::OP_W-1:0]   opcode,
	output logic                        m_tvalid,
	input  wire                         m_tready,
	input  wire  nftl_pkg::dp_sts_t     sts,
	output nftl_pkg::dp_cmd_t           cmd
);
	import nftl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_OUT
	} state_t;

	state_t state_q;
	logic   accept;
	logic   out_free;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	// decode commands from the state
	always_comb begin
		cmd            = '0;
		cmd.latch_in   = accept;
		cmd.scan_start = accept && (opcode == OP_QUERY);
		cmd.exec       = (state_q == S_EXEC);
		cmd.scan_run   = (state_q == S_SCAN);
		cmd.load_res   = (state_q == S_EXEC) ||
		                 ((state_q == S_SCAN) && (sts.scan_hit || sts.scan_end));
		cmd.load_out   = (state_q == S_OUT) && out_free;
	end

	// hold state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (opcode == OP_QUERY) ? S_SCAN : S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_OUT;
				end
				S_SCAN: begin
					if (sts.scan_hit || sts.scan_end) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/nftl_dp.sv -----
// Datapath of the tuner table: entry memory, entry count, band register,
// scan pipeline with candidate tracking, result and output registers. Uses nftl_pkg.
`default_nettype none

module nftl_dp (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  nftl_pkg::dp_cmd_t       cmd,
	output nftl_pkg::dp_sts_t             sts,
	input  wire  [nftl_pkg::OP_W-1:0]     in_opcode,
	input  wire  nftl_pkg::entry_t        in_entry,
	input  wire                           cfg_we,
	input  wire  [nftl_pkg::BAND_W-1:0]   cfg_wdata,
	output nftl_pkg::res_t                out_res
);
	import nftl_pkg::*;

	entry_t              mem_q [TABLE_ENTRIES];
	logic [CNT_W-1:0]    count_q;
	logic [BAND_W-1:0]   band_q;
	logic [OP_W-1:0]     op_q;
	entry_t              in_q;

	logic [CNT_W-1:0]    rd_idx_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	entry_t              rd_data_s1;

	logic                have_low_q;
	logic [FREQ_W-1:0]   low_dist_q;
	logic [IDX_W-1:0]    low_idx_q;
	entry_t              low_data_q;

	res_t                res_q;
	res_t                res_d;

	logic                issue;
	logic                full;
	logic [FREQ_W-1:0]   delta;
	logic                in_band;
	logic                at_or_above;
	logic                closer;
	logic                hit;
	logic                scan_end;

	assign full  = (count_q >= CNT_W'(TABLE_ENTRIES));
	assign issue = cmd.scan_run && (rd_idx_q < count_q);

	// band register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= BAND_RESET;
		end else if (cfg_we) begin
			band_q <= cfg_wdata;
		end
	end

	// latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q <= in_opcode;
			in_q <= in_entry;
		end
	end

	// entry count: clear empties, an accepted append advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (op_q == OP_CLEAR) begin
				count_q <= '0;
			end else if ((op_q == OP_APPEND) && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.exec && (op_q == OP_APPEND) && !full) begin
			mem_q[count_q[IDX_W-1:0]] <= in_q;
		end
		rd_data_s1 <= mem_q[rd_idx_q[IDX_W-1:0]];
		rd_idx_s1  <= rd_idx_q[IDX_W-1:0];
	end

	// scan address and read-valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else if (cmd.scan_start) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
		end
	end

	// compare the entry just read against the asked frequency
	always_comb begin
		delta       = (rd_data_s1.freq >= in_q.freq) ? (rd_data_s1.freq - in_q.freq)
		                                              : (in_q.freq - rd_data_s1.freq);
		in_band     = (delta <= FREQ_W'(band_q));
		at_or_above = (rd_data_s1.freq >= in_q.freq);
		closer      = !have_low_q || (delta < low_dist_q);
		hit         = cmd.scan_run && rd_vld_s1 && in_band && at_or_above;
		scan_end    = cmd.scan_run && !rd_vld_s1 && (rd_idx_q >= count_q);
	end

	assign sts.scan_hit = hit;
	assign sts.scan_end = scan_end;

	// track the nearest in-band entry below the query; ties keep the earlier one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_low_q <= 1'b0;
		end else if (cmd.scan_start) begin
			have_low_q <= 1'b0;
		end else if (cmd.scan_run && rd_vld_s1 && in_band && !at_or_above && closer) begin
			have_low_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_run && rd_vld_s1 && in_band && !at_or_above && closer) begin
			low_dist_q <= delta;
			low_idx_q  <= rd_idx_s1;
			low_data_q <= rd_data_s1;
		end
	end

	// select the result of the finished item
	always_comb begin
		res_d = '0;
		if (cmd.exec) begin
			if ((op_q == OP_APPEND) && full) begin
				res_d.status = ST_FULL;
			end else begin
				res_d.status = ST_DONE;
			end
		end else if (hit) begin
			res_d.status = ST_MATCH;
			if (closer) begin
				res_d.index = OUT_IDX_W'(rd_idx_s1);
				res_d.entry = rd_data_s1;
			end else begin
				res_d.index = OUT_IDX_W'(low_idx_q);
				res_d.entry = low_data_q;
			end
		end else if (have_low_q) begin
			res_d.status = ST_MATCH;
			res_d.index  = OUT_IDX_W'(low_idx_q);
			res_d.entry  = low_data_q;
		end else begin
			res_d.status = ST_NOT_FOUND;
		end
	end

	// result register, then output register that holds while stalled
	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			res_q <= res_d;
		end
		if (cmd.load_out) begin
			out_res <= res_q;
		end
	end

endmodule

`default_nettype wire

// ----- design/nearest_frequency_table_lookup.sv -----
// Nearest-frequency tuner table: clear, append and nearest-in-band query items.
// Sequencing: clear, append and ignored opcodes pass through an execute state to the output
// register; a query reads the stored entries in order, one memory read per entry, and stops
// early at the first in-band entry at or above the asked frequency.
// A new item is taken only after the last has reached the output register; a waiting result still lets one transfer in.
// Reset: asynchronous, active low; empties the table and sets band_window to 1000.
`default_nettype none

module nearest_frequency_table_lookup (
	input  wire         clk,
	input  wire         arst_n,
	// s_tdata: frequency[23:0], antenna port[27:24], transfer port[31:28],
	// network_shape[35:32], inductor_setting[51:36], capacitor_setting[67:52], zero pad
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [71:0] s_tdata,
	input  wire  [1:0]  s_tuser,   // opcode[1:0]
	// m_tdata: out_index[7:0], out_freq[31:8], out_ant[35:32], out_xfer[39:36],
	// out_shape[43:40], out_inductor[59:44], out_capacitor[75:60], zero pad
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [79:0] m_tdata,
	output logic [1:0]  m_tuser,   // status[1:0]
	input  wire         cfg_we,
	input  wire  [15:0] cfg_wdata
);
	import nftl_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	entry_t  in_entry;
	res_t    out_res;

	// unpack the input transfer
	always_comb begin
		in_entry.freq      = s_tdata[23:0];
		in_entry.ant       = s_tdata[27:24];
		in_entry.xfer      = s_tdata[31:28];
		in_entry.shape     = s_tdata[35:32];
		in_entry.inductor  = s_tdata[51:36];
		in_entry.capacitor = s_tdata[67:52];
	end

	nftl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nftl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_opcode (s_tuser),
		.in_entry  (in_entry),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_res   (out_res)
	);

	// pack the result transfer
	assign m_tuser = out_res.status;
	assign m_tdata = {4'd0,
	                  out_res.entry.capacitor,
	                  out_res.entry.inductor,
	                  out_res.entry.shape,
	                  out_res.entry.xfer,
	                  out_res.entry.ant,
	                  out_res.entry.freq,
	                  out_res.index};

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the nearest-frequency tuner table.
// Drives clear, append and query transfers with random gaps and stalls and checks every
// result against an in-bench prediction; depends on nftl_pkg and the top-level RTL only.

module tb;

	import nftl_pkg::*;

	localparam logic [OP_W-1:0]   OP_IGNORED   = 2'd3;
	localparam logic [FREQ_W-1:0] FREQ_MAX     = {FREQ_W{1'b1}};
	localparam int                ITEM_TARGET  = 900;
	localparam int                LIMIT_CYCLES = 1_500_000;
	localparam int                SETTLE_TAIL  = 270;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	// predicted table contents and register
	entry_t            tuner_table [TABLE_ENTRIES];
	int unsigned       tuner_count;
	logic [BAND_W-1:0] band_window_model;
	res_t              pending_results [$];

	int  err_count;
	int  items_sent;
	int  cycle_count;
	bit  no_gaps;

	nearest_frequency_table_lookup uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// stop a hung run
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t timeout after %0d cycles", $time, cycle_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic entry_t mk_entry(input logic [FREQ_W-1:0] f, input logic [PORT_W-1:0] a,
		input logic [PORT_W-1:0] x, input logic [PORT_W-1:0] s,
		input logic [STEP_W-1:0] l, input logic [STEP_W-1:0] c);
		entry_t e;
		e.freq      = f;
		e.ant       = a;
		e.xfer      = x;
		e.shape     = s;
		e.inductor  = l;
		e.capacitor = c;
		return e;
	endfunction

	function automatic entry_t random_entry(input logic [FREQ_W-1:0] f);
		return mk_entry(f, PORT_W'($urandom_range(0, 15)), PORT_W'($urandom_range(0, 15)),
			PORT_W'($urandom_range(0, 15)), STEP_W'($urandom_range(0, 65535)),
			STEP_W'($urandom_range(0, 65535)));
	endfunction

	// any frequency of the field range
	function automatic logic [FREQ_W-1:0] rand_freq();
		return FREQ_W'($urandom_range(0, FREQ_MAX));
	endfunction

	// pick a frequency within spread of centre, clamped to the field range
	function automatic logic [FREQ_W-1:0] near_freq(input longint centre, input longint spread);
		longint off;
		longint f;
		off = $urandom_range(0, 32'(spread));
		f   = $urandom_range(0, 1) ? centre + off : centre - off;
		if (f < 0)
			f = 0;
		if (f > FREQ_MAX)
			f = FREQ_MAX;
		return f[FREQ_W-1:0];
	endfunction

	// update the predicted table and work out the result of one transfer
	function automatic res_t apply_tuner_item(input logic [OP_W-1:0] op, input entry_t item);
		res_t        res;
		bit          have_low;
		bit          found;
		int unsigned low_idx;
		int unsigned low_dist;
		int unsigned pick;
		int unsigned e;
		int unsigned f;
		int unsigned d;
		res      = '0;
		res.status = ST_DONE;
		have_low = 0;
		found    = 0;
		low_idx  = 0;
		low_dist = 0;
		pick     = 0;
		f        = item.freq;
		case (op)
			OP_CLEAR: begin
				tuner_count = 0;
			end
			OP_APPEND: begin
				if (tuner_count >= TABLE_ENTRIES) begin
					res.status = ST_FULL;
				end else begin
					tuner_table[tuner_count] = item;
					tuner_count = tuner_count + 1;
				end
			end
			OP_QUERY: begin
				// stop at the first in-band entry at or above the asked frequency
				for (int i = 0; i < tuner_count && !found; i++) begin
					e = tuner_table[i].freq;
					d = (e >= f) ? e - f : f - e;
					if (d <= band_window_model) begin
						if (e >= f) begin
							pick  = (!have_low || d < low_dist) ? i : low_idx;
							found = 1;
						end else if (!have_low || d < low_dist) begin
							have_low = 1;
							low_dist = d;
							low_idx  = i;
						end
					end
				end
				if (!found && have_low) begin
					pick  = low_idx;
					found = 1;
				end
				if (found) begin
					res.status = ST_MATCH;
					res.index  = pick[OUT_IDX_W-1:0];
					res.entry  = tuner_table[pick];
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// present one item after a random gap and hold it until the transfer
	task automatic send_item(input logic [OP_W-1:0] op, input entry_t item);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {4'd0, item.capacitor, item.inductor, item.shape, item.xfer, item.ant,
			item.freq};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(apply_tuner_item(op, item));
		items_sent = items_sent + 1;
	endtask

	// hold off the sender until every outstanding result has come back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_band_window(input logic [BAND_W-1:0] value);
		drain_results();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		band_window_model = value;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$display("%0t mismatch %s: expected %0h, actual %0h", $time, name, exp, act);
			err_count = err_count + 1;
		end
	endtask

	// receive results with random stalls and compare each with the oldest prediction
	initial begin : result_monitor
		res_t exp;
		int   stall;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			stall = no_gaps ? 0 : $urandom_range(0, 14);
			if (stall != 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: status %0h data %0h", $time, m_tuser, m_tdata);
				err_count = err_count + 1;
			end else begin
				exp = pending_results.pop_front();
				check_field("status",    32'(exp.status),          32'(m_tuser));
				check_field("index",     32'(exp.index),           32'(m_tdata[7:0]));
				check_field("freq",      32'(exp.entry.freq),      32'(m_tdata[31:8]));
				check_field("ant",       32'(exp.entry.ant),       32'(m_tdata[35:32]));
				check_field("xfer",      32'(exp.entry.xfer),      32'(m_tdata[39:36]));
				check_field("shape",     32'(exp.entry.shape),     32'(m_tdata[43:40]));
				check_field("inductor",  32'(exp.entry.inductor),  32'(m_tdata[59:44]));
				check_field("capacitor", 32'(exp.entry.capacitor), 32'(m_tdata[75:60]));
			end
		end
	end

	// edges of the band, ties, missing neighbours and an out-of-order entry at reset window
	task automatic test_basic_lookup();
		send_item(OP_QUERY, random_entry(24'd5000));
		send_item(OP_IGNORED, mk_entry(24'd0, 4'd0, 4'd0, 4'd0, 16'd0, 16'd0));
		send_item(OP_APPEND, mk_entry(24'd0, 4'd0, 4'd0, 4'd0, 16'd0, 16'd0));
		send_item(OP_APPEND, mk_entry(24'd10000, 4'hF, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF));
		send_item(OP_APPEND, mk_entry(24'd11000, 4'd5, 4'd10, 4'd3, 16'd1234, 16'd4321));
		send_item(OP_APPEND, mk_entry(FREQ_MAX, 4'hF, 4'd0, 4'hF, 16'd0, 16'hFFFF));
		send_item(OP_QUERY, random_entry(24'd0));
		send_item(OP_QUERY, random_entry(24'd9500));
		send_item(OP_QUERY, random_entry(24'd10500));
		send_item(OP_QUERY, random_entry(24'd10700));
		send_item(OP_QUERY, random_entry(24'd11900));
		send_item(OP_QUERY, random_entry(24'd13000));
		send_item(OP_QUERY, random_entry(FREQ_MAX - 24'd1000));
		// nearer entry sits behind the first upper candidate
		send_item(OP_APPEND, random_entry(24'd10200));
		send_item(OP_QUERY, random_entry(24'd10250));
		// equal lower distances keep the earlier entry
		send_item(OP_CLEAR, random_entry(24'd0));
		send_item(OP_APPEND, random_entry(24'd20000));
		send_item(OP_APPEND, random_entry(24'd20000));
		send_item(OP_QUERY, random_entry(24'd20400));
		send_item(OP_IGNORED, mk_entry(FREQ_MAX, 4'hF, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF));
	endtask

	task automatic test_window_extremes();
		set_band_window(16'd1);
		send_item(OP_CLEAR, random_entry(24'd0));
		send_item(OP_APPEND, random_entry(24'd100));
		send_item(OP_APPEND, random_entry(24'd102));
		send_item(OP_QUERY, random_entry(24'd101));
		send_item(OP_QUERY, random_entry(24'd103));
		send_item(OP_QUERY, random_entry(24'd99));
		// exact matches only
		set_band_window(16'd0);
		send_item(OP_QUERY, random_entry(24'd101));
		send_item(OP_QUERY, random_entry(24'd102));
		set_band_window(16'hFFFF);
		send_item(OP_CLEAR, random_entry(24'd0));
		send_item(OP_APPEND, random_entry(24'd0));
		send_item(OP_APPEND, random_entry(FREQ_MAX));
		send_item(OP_QUERY, random_entry(24'd65535));
		send_item(OP_QUERY, random_entry(24'd65536));
		send_item(OP_QUERY, random_entry(FREQ_MAX - 24'd65535));
	endtask

	// fill every slot, refuse further appends and run full-length scans
	task automatic test_table_full();
		longint      f;
		int unsigned w;
		set_band_window(BAND_W'($urandom_range(500, 3000)));
		w = band_window_model;
		send_item(OP_CLEAR, random_entry(24'd0));
		f = $urandom_range(0, 1000);
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			send_item(OP_APPEND, random_entry(f[FREQ_W-1:0]));
			f = f + $urandom_range(0, 2 * w);
			if (f > FREQ_MAX)
				f = FREQ_MAX;
		end
		for (int k = 0; k < 3; k++)
			send_item(OP_APPEND, random_entry(rand_freq()));
		drain_results();
		send_item(OP_QUERY, random_entry(FREQ_MAX));
		send_item(OP_QUERY, random_entry(tuner_table[TABLE_ENTRIES-1].freq));
		for (int k = 0; k < 6; k++)
			send_item(OP_QUERY, random_entry(near_freq(
				tuner_table[$urandom_range(0, TABLE_ENTRIES - 1)].freq, w + w / 4)));
		send_item(OP_CLEAR, random_entry(24'd0));
		send_item(OP_QUERY, random_entry(rand_freq()));
	endtask

	// mostly ascending tables with targeted queries, plus out-of-order entries and noise
	task automatic test_random_traffic();
		int          n_app;
		int          n_qry;
		longint      f;
		int unsigned w;
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 5))
					0: set_band_window(16'd1);
					1: set_band_window(16'hFFFF);
					2: set_band_window(16'd0);
					3: set_band_window(BAND_W'($urandom_range(1, 100)));
					default: set_band_window(BAND_W'($urandom_range(1, 5000)));
				endcase
			end
			no_gaps = ($urandom_range(0, 4) == 0);
			w = band_window_model;
			if ($urandom_range(0, 4) != 0)
				send_item(OP_CLEAR, random_entry(rand_freq()));
			n_app = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
			case ($urandom_range(0, 5))
				0: f = 0;
				1: f = FREQ_MAX - $urandom_range(0, 4 * w + 4);
				default: f = $urandom_range(0, FREQ_MAX);
			endcase
			if (f < 0)
				f = 0;
			for (int k = 0; k < n_app; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(OP_APPEND, random_entry(rand_freq()));
				end else begin
					send_item(OP_APPEND, random_entry(f[FREQ_W-1:0]));
					f = f + $urandom_range(0, 2 * w + 2);
					if (f > FREQ_MAX)
						f = FREQ_MAX;
				end
			end
			n_qry = $urandom_range(1, 8);
			for (int k = 0; k < n_qry; k++) begin
				case ($urandom_range(0, 9))
					0: send_item(OP_QUERY, random_entry(rand_freq()));
					1: send_item(OP_IGNORED, random_entry(rand_freq()));
					2: begin
						if (tuner_count == 0)
							send_item(OP_QUERY, random_entry(rand_freq()));
						else
							send_item(OP_QUERY, random_entry(
								tuner_table[$urandom_range(0, tuner_count - 1)].freq));
					end
					default: begin
						if (tuner_count == 0)
							send_item(OP_QUERY, random_entry(near_freq(f, w + 1)));
						else
							send_item(OP_QUERY, random_entry(near_freq(
								tuner_table[$urandom_range(0, tuner_count - 1)].freq,
								w + w / 4 + 1)));
					end
				endcase
			end
			if ($urandom_range(0, 5) == 0)
				drain_results();
		end
		no_gaps = 0;
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = OP_CLEAR;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		err_count   = 0;
		items_sent  = 0;
		no_gaps     = 0;
		tuner_count = 0;
		band_window_model = BAND_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_lookup();
		test_window_extremes();
		test_table_full();
		test_random_traffic();

		drain_results();
		repeat (SETTLE_TAIL) @(posedge clk);
		if (err_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/nftl_pkg.sv
design/nftl_ctrl.sv
design/nftl_dp.sv
design/nearest_frequency_table_lookup.sv
dv/tb.sv
